FILE: sv/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg
// shared types and constants for the path reservation table
// ----------------------------------------------------------------------------
package prt_pkg;

  localparam int NUM_LOCATIONS_DEF = 1024;
  localparam int HORIZON_DEF       = 256;
  localparam int MAX_AGENTS_DEF    = 256;

  // request operation codes
  localparam logic [2:0] OP_CONFLICT = 3'd0;
  localparam logic [2:0] OP_BLOCKED  = 3'd1;
  localparam logic [2:0] OP_INSERT   = 3'd2;
  localparam logic [2:0] OP_DELETE   = 3'd3;
  localparam logic [2:0] OP_OCCUPANT = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_HORIZON_LAST = 2'd0;
  localparam logic [1:0] CFG_AGENT_COUNT  = 2'd1;

  localparam logic [7:0] HORIZON_LAST_RST = 8'd255;
  localparam logic [8:0] AGENT_COUNT_RST  = 9'd256;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RL,
    ST_WL,
    ST_SCAN_RD,
    ST_SCAN_CK,
    ST_RX,
    ST_WX,
    ST_Q1,
    ST_Q2,
    ST_Q3,
    ST_Q4,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    RD_L,
    RD_X,
    RD_LPREV,
    RD_P,
    RD_SCAN
  } rd_sel_t;

  typedef struct packed {
    logic    clear;
    logic    latch;
    logic    start;
    logic    wr_l;
    logic    wr_x;
    logic    scan_init;
    logic    scan_x;
    logic    scan_dec;
    logic    scan_fin;
    logic    cap1;
    logic    cap2;
    logic    cap3;
    logic    load_out;
    rd_sel_t rd_sel;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic do_x;
    logic scan_l;
    logic scan_xn;
    logic scan_neg;
    logic scan_hit;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/path_reservation_table.sv
// ----------------------------------------------------------------------------
// path_reservation_table
// space-time reservation table for multi-agent path planning
// ----------------------------------------------------------------------------
// requests enter on the s_ stream (op in s_tuser, fields in s_tdata) and one
// result per request leaves on the m_ stream. registers are written through
// cfg_valid/cfg_index/cfg_data, always ready; the user must write them only
// while the block is idle, and the block itself does not enforce it.
// one request is worked at a time; the cell memory has a single read port
// and each read lands in the next cycle. a request reads and updates its
// location cell, then its exit cell when one is touched, and a delete may
// rescan earlier timesteps of either cell for its new latest time.
// after reset a clearing pass writes every cell free and clears the usage
// and latest-time tables; s_tready stays low during it.
// a finished result sits in the output register; the next request is taken
// while it waits, and that request stalls only at its own result load until
// m_tready frees the register.
// ----------------------------------------------------------------------------
module path_reservation_table #(
  parameter int NUM_LOCATIONS = prt_pkg::NUM_LOCATIONS_DEF,
  parameter int HORIZON       = prt_pkg::HORIZON_DEF,
  parameter int MAX_AGENTS    = prt_pkg::MAX_AGENTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // agent, location, time_step, previous_location, exit_flag, exit_location,
  // path_start
  input  logic [55:0] s_tdata,
  // op
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // hit, occupant_valid, occupant, latest_time
  output logic [23:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  prt_pkg::cmd_t cmd;
  prt_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  prt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  prt_dp #(
    .NUM_LOCATIONS (NUM_LOCATIONS),
    .HORIZON       (HORIZON),
    .MAX_AGENTS    (MAX_AGENTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

FILE: sv/prt_dp.sv
// ----------------------------------------------------------------------------
// prt_dp
// datapath: cell, usage and latest-time memories, request and result registers
// ----------------------------------------------------------------------------
module prt_dp #(
  parameter int NUM_LOCATIONS = prt_pkg::NUM_LOCATIONS_DEF,
  parameter int HORIZON       = prt_pkg::HORIZON_DEF,
  parameter int MAX_AGENTS    = prt_pkg::MAX_AGENTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  prt_pkg::cmd_t cmd,
  output prt_pkg::sts_t sts,
  input  logic [55:0]   s_tdata,
  input  logic [2:0]    s_tuser,
  input  logic          cfg_valid,
  input  logic [1:0]    cfg_index,
  input  logic [8:0]    cfg_data,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [23:0]   m_tdata
);

  localparam int LW         = (NUM_LOCATIONS > 1) ? $clog2(NUM_LOCATIONS) : 1;
  localparam int TW         = (HORIZON > 1) ? $clog2(HORIZON) : 1;
  localparam int AW         = LW + TW;
  localparam int CELL_DEPTH = NUM_LOCATIONS * (2 ** TW);

  logic [31:0]        cells    [CELL_DEPTH];
  logic               used_mem [NUM_LOCATIONS];
  logic signed [TW:0] lat_mem  [NUM_LOCATIONS];

  logic [7:0] horizon_last;
  logic [8:0] agent_count;

  logic [2:0]  op_q;
  logic [7:0]  agent_q;
  logic [10:0] loc_q;
  logic [8:0]  t_q;
  logic [10:0] pre_q;
  logic        xf_q;
  logic [9:0]  xloc_q;
  logic        ps_q;

  logic        path_stopped;
  logic        mod_q;
  logic [31:0] code_q;

  logic [AW-1:0]      clr_cnt;
  logic signed [TW:0] scan_s;
  logic [LW-1:0]      scan_loc;

  logic [31:0]        cell_rd;
  logic               used_rd;
  logic signed [TW:0] lat_rd;

  logic [31:0]        cv_q, cprev_q, cp_q;
  logic               ul_q, up_q;
  logic signed [TW:0] ll_q;

  logic [AW-1:0]      cell_ra, cell_wa;
  logic [LW-1:0]      loc_ra, used_wa, lat_wa;
  logic               cell_we, used_we, lat_we, used_wd;
  logic [31:0]        cell_wd;
  logic signed [TW:0] lat_wd;

  logic [LW-1:0] la, pa, xa;
  logic [TW-1:0] ta, tpa;
  logic          loc_ok, pre_ok, x_ok, t_in, is_mod, is_ins, stopped_eff, mod_now, do_x;
  logic [31:0]   agents, inc, x_sub;
  logic signed [31:0] lat32, t32, lat_out32;
  logic signed [TW:0] tlat;
  logic          ovalid, hit;
  logic [8:0]    occ, latest;

  assign la  = LW'(loc_q[9:0]);
  assign pa  = LW'(pre_q[9:0]);
  assign xa  = LW'(xloc_q);
  assign ta  = TW'(t_q);
  assign tpa = TW'(t_q - 9'd1);

  assign loc_ok = !loc_q[10] && (32'(loc_q[9:0]) < NUM_LOCATIONS);
  assign pre_ok = !pre_q[10] && (32'(pre_q[9:0]) < NUM_LOCATIONS);
  assign x_ok   = 32'(xloc_q) < NUM_LOCATIONS;
  assign t_in   = (32'(t_q) <= 32'(horizon_last)) && (32'(t_q) < HORIZON);
  assign agents = (32'(agent_count) < MAX_AGENTS) ? 32'(agent_count) : 32'(MAX_AGENTS);
  assign inc    = 32'(agent_q) + 32'd1;

  assign is_mod      = (op_q == prt_pkg::OP_INSERT) || (op_q == prt_pkg::OP_DELETE);
  assign is_ins      = op_q == prt_pkg::OP_INSERT;
  assign stopped_eff = ps_q ? 1'b0 : path_stopped;
  assign mod_now     = is_mod && !stopped_eff && t_in && loc_ok;
  assign do_x        = mod_q && xf_q && x_ok;

  assign lat32 = 32'(lat_rd);
  assign t32   = 32'(t_q);
  assign tlat  = (TW+1)'(t_q);
  assign x_sub = cell_rd - code_q;

  // request, control and config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      horizon_last <= prt_pkg::HORIZON_LAST_RST;
      agent_count  <= prt_pkg::AGENT_COUNT_RST;
      path_stopped <= 1'b0;
      mod_q        <= 1'b0;
      clr_cnt      <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          prt_pkg::CFG_HORIZON_LAST: horizon_last <= cfg_data[7:0];
          prt_pkg::CFG_AGENT_COUNT:  agent_count  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clear) clr_cnt <= clr_cnt + AW'(1);
      if (cmd.start) begin
        mod_q <= mod_now;
        if (is_mod) path_stopped <= stopped_eff || loc_q[10];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q    <= s_tuser;
      agent_q <= s_tdata[7:0];
      loc_q   <= s_tdata[18:8];
      t_q     <= s_tdata[27:19];
      pre_q   <= s_tdata[38:28];
      xf_q    <= s_tdata[39];
      xloc_q  <= s_tdata[49:40];
      ps_q    <= s_tdata[50];
    end
    if (cmd.start) code_q <= inc * agents + 32'd1;
    if (cmd.scan_init) begin
      scan_s   <= tlat - (TW+1)'(1);
      scan_loc <= cmd.scan_x ? xa : la;
    end else if (cmd.scan_dec) begin
      scan_s <= scan_s - (TW+1)'(1);
    end
    if (cmd.cap1) begin
      cv_q <= cell_rd;
      ul_q <= used_rd;
      ll_q <= lat_rd;
    end
    if (cmd.cap2) begin
      cprev_q <= cell_rd;
      up_q    <= used_rd;
    end
    if (cmd.cap3) cp_q <= cell_rd;
  end

  // read address select
  always_comb begin
    cell_ra = {la, ta};
    loc_ra  = la;
    case (cmd.rd_sel)
      prt_pkg::RD_L:     begin cell_ra = {la, ta};  loc_ra = la; end
      prt_pkg::RD_X:     begin cell_ra = {xa, ta};  loc_ra = xa; end
      prt_pkg::RD_LPREV: begin cell_ra = {la, tpa}; loc_ra = pa; end
      prt_pkg::RD_P:     begin cell_ra = {pa, ta};  loc_ra = pa; end
      prt_pkg::RD_SCAN: begin
        cell_ra = {scan_loc, scan_s[TW-1:0]};
        loc_ra  = scan_loc;
      end
      default: ;
    endcase
  end

  // write port select
  always_comb begin
    cell_we = 1'b0; cell_wa = {la, ta}; cell_wd = cell_rd;
    used_we = 1'b0; used_wa = la;       used_wd = 1'b1;
    lat_we  = 1'b0; lat_wa  = la;       lat_wd  = tlat;
    if (cmd.clear) begin
      cell_we = 1'b1;
      cell_wa = clr_cnt;
      cell_wd = '1;
      used_we = 32'(clr_cnt) < NUM_LOCATIONS;
      used_wa = LW'(clr_cnt);
      used_wd = 1'b0;
      lat_we  = 32'(clr_cnt) < NUM_LOCATIONS;
      lat_wa  = LW'(clr_cnt);
      lat_wd  = '1;
    end else if (cmd.wr_l && mod_q) begin
      if (is_ins) begin
        cell_we = 1'b1;
        cell_wd = cell_rd + inc;
        used_we = 1'b1;
        lat_we  = lat32 < t32;
      end else begin
        cell_we = used_rd;
        cell_wd = cell_rd - inc;
      end
    end else if (cmd.wr_x && do_x) begin
      cell_wa = {xa, ta};
      used_wa = xa;
      lat_wa  = xa;
      if (is_ins) begin
        cell_we = 1'b1;
        cell_wd = cell_rd + code_q;
        used_we = 1'b1;
        lat_we  = cell_rd[31] && (lat32 < t32);
      end else begin
        cell_we = used_rd;
        cell_wd = x_sub;
      end
    end else if (cmd.scan_fin) begin
      lat_we = 1'b1;
      lat_wa = scan_loc;
      lat_wd = scan_s;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_we) cells[cell_wa] <= cell_wd;
    cell_rd <= cells[cell_ra];
  end

  always_ff @(posedge clk) begin
    if (used_we) used_mem[used_wa] <= used_wd;
    used_rd <= used_mem[loc_ra];
  end

  always_ff @(posedge clk) begin
    if (lat_we) lat_mem[lat_wa] <= lat_wd;
    lat_rd <= lat_mem[loc_ra];
  end

  // result from the captured post-update reads
  assign lat_out32 = 32'(ll_q);

  always_comb begin
    ovalid = loc_ok && ul_q && t_in && !cv_q[31] && (cv_q < agents);
    occ    = ovalid ? cv_q[8:0] : '1;
    latest = loc_ok ? lat_out32[8:0] : '1;
    hit    = 1'b0;
    case (op_q)
      prt_pkg::OP_CONFLICT: begin
        if (loc_ok && ul_q) begin
          if (!t_in || !cv_q[31]) begin
            hit = 1'b1;
          end else if (pre_ok && up_q && (t_q != 9'd0)) begin
            // edge swap: the pair swaps cells between t-1 and t
            hit = !cprev_q[31] && (cprev_q == cp_q);
          end
        end
      end
      prt_pkg::OP_BLOCKED:  hit = !t_in || (loc_ok && ul_q && !cv_q[31]);
      prt_pkg::OP_OCCUPANT: hit = ovalid;
      default:              hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) m_tdata <= {4'b0, latest, occ, ovalid, hit};
  end

  assign sts.clr_done = clr_cnt == AW'(CELL_DEPTH - 1);
  assign sts.do_x     = do_x;
  assign sts.scan_l   = mod_q && !is_ins && used_rd && (lat32 == t32);
  assign sts.scan_xn  = do_x && !is_ins && used_rd && (x_sub == '1) && (lat32 == t32);
  assign sts.scan_neg = scan_s[TW];
  assign sts.scan_hit = !cell_rd[31];
  assign sts.out_free = !m_tvalid || m_tready;

endmodule

FILE: sv/prt_ctrl.sv
// ----------------------------------------------------------------------------
// prt_ctrl
// controller: sequences memory reads, updates, rescans and the result load
// ----------------------------------------------------------------------------
module prt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  prt_pkg::sts_t sts,
  output prt_pkg::cmd_t cmd
);

  prt_pkg::state_t state, state_next;
  logic scan_on_x, scan_on_x_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= prt_pkg::ST_CLEAR;
      scan_on_x <= 1'b0;
    end else begin
      state     <= state_next;
      scan_on_x <= scan_on_x_next;
    end
  end

  always_comb begin
    state_next     = state;
    scan_on_x_next = scan_on_x;
    cmd            = '0;
    cmd.rd_sel     = prt_pkg::RD_L;
    s_tready       = 1'b0;
    case (state)
      prt_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_done) state_next = prt_pkg::ST_IDLE;
      end
      prt_pkg::ST_IDLE: begin
        s_tready  = 1'b1;
        cmd.latch = s_tvalid;
        if (s_tvalid) state_next = prt_pkg::ST_RL;
      end
      prt_pkg::ST_RL: begin
        cmd.start  = 1'b1;
        state_next = prt_pkg::ST_WL;
      end
      prt_pkg::ST_WL: begin
        cmd.wr_l = 1'b1;
        if (sts.scan_l) begin
          cmd.scan_init  = 1'b1;
          scan_on_x_next = 1'b0;
          state_next     = prt_pkg::ST_SCAN_RD;
        end else if (sts.do_x) begin
          state_next = prt_pkg::ST_RX;
        end else begin
          state_next = prt_pkg::ST_Q1;
        end
      end
      prt_pkg::ST_SCAN_RD: begin
        cmd.rd_sel = prt_pkg::RD_SCAN;
        if (sts.scan_neg) begin
          cmd.scan_fin = 1'b1;
          state_next   = (!scan_on_x && sts.do_x) ? prt_pkg::ST_RX : prt_pkg::ST_Q1;
        end else begin
          state_next = prt_pkg::ST_SCAN_CK;
        end
      end
      prt_pkg::ST_SCAN_CK: begin
        cmd.rd_sel = prt_pkg::RD_SCAN;
        if (sts.scan_hit) begin
          cmd.scan_fin = 1'b1;
          state_next   = (!scan_on_x && sts.do_x) ? prt_pkg::ST_RX : prt_pkg::ST_Q1;
        end else begin
          cmd.scan_dec = 1'b1;
          state_next   = prt_pkg::ST_SCAN_RD;
        end
      end
      prt_pkg::ST_RX: begin
        cmd.rd_sel = prt_pkg::RD_X;
        state_next = prt_pkg::ST_WX;
      end
      prt_pkg::ST_WX: begin
        cmd.wr_x = 1'b1;
        if (sts.scan_xn) begin
          cmd.scan_init  = 1'b1;
          cmd.scan_x     = 1'b1;
          scan_on_x_next = 1'b1;
          state_next     = prt_pkg::ST_SCAN_RD;
        end else begin
          state_next = prt_pkg::ST_Q1;
        end
      end
      prt_pkg::ST_Q1: begin
        cmd.rd_sel = prt_pkg::RD_L;
        state_next = prt_pkg::ST_Q2;
      end
      prt_pkg::ST_Q2: begin
        cmd.cap1   = 1'b1;
        cmd.rd_sel = prt_pkg::RD_LPREV;
        state_next = prt_pkg::ST_Q3;
      end
      prt_pkg::ST_Q3: begin
        cmd.cap2   = 1'b1;
        cmd.rd_sel = prt_pkg::RD_P;
        state_next = prt_pkg::ST_Q4;
      end
      prt_pkg::ST_Q4: begin
        cmd.cap3   = 1'b1;
        state_next = prt_pkg::ST_FIN;
      end
      prt_pkg::ST_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = prt_pkg::ST_IDLE;
        end
      end
      default: state_next = prt_pkg::ST_CLEAR;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == prt_pkg::ST_RL))
    else $error("accepted request did not start the sequence");

  a_scan_pairs: assert property (@(posedge clk) disable iff (rst)
    (state == prt_pkg::ST_SCAN_CK) |-> ($past(state) == prt_pkg::ST_SCAN_RD))
    else $error("scan check without a scan read");

  a_load_frees: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> (state == prt_pkg::ST_IDLE) && s_tready)
    else $error("result load did not return to idle");

endmodule
